@@ sv/mkt_pkg.sv @@
// Package for the MIDI kick tempo tracker: shared constants, the sequencer
// state type and the divider status struct.
// No dependencies.
package mkt_pkg;

	localparam int DEF_WINDOW_DEPTH  = 8;
	localparam int DEF_MIN_INTERVALS = 4;

	// Quotient bits produced by the shared divider, one per cycle.
	localparam int DIV_Q_W = 16;

	localparam logic [1:0] STATUS_NOTE_ON  = 2'd1;
	localparam logic [1:0] STATUS_NOTE_OFF = 2'd2;

	localparam logic [6:0] KICK_PITCH_A = 7'd36;
	localparam logic [6:0] KICK_PITCH_B = 7'd35;

	localparam logic [6:0]  BARS_RESET  = 7'd8;
	localparam logic [10:0] TEMPO_RESET = 11'd1200;
	localparam logic [10:0] TEMPO_MIN   = 11'd600;
	localparam logic [10:0] TEMPO_MAX   = 11'd2000;
	localparam logic [15:0] RELEASE_Q16 = 16'd45875;

	localparam int MEAN_LOW_MS  = 100;
	localparam int MEAN_HIGH_MS = 2000;
	// Twice the 600000 tenths-of-BPM numerator, for round-half-up division.
	localparam int TEMPO_NUM2   = 1200000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MDIV,
		ST_SUM,
		ST_CHECK,
		ST_TDIV,
		ST_FINISH
	} mkt_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

@@ sv/mkt_ifs.sv @@
// Handshake channels of the tempo tracker: configuration writes, MIDI
// events in and results out. Depends on nothing.
interface mkt_cfg_if;
	logic       valid;
	logic       ready;
	logic [6:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface mkt_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  note_status;
	logic [6:0]  note_pitch;
	logic [6:0]  note_velocity;
	logic [31:0] time_ms;

	modport source (output valid, output note_status, output note_pitch,
		output note_velocity, output time_ms, input ready);
	modport sink   (input valid, input note_status, input note_pitch,
		input note_velocity, input time_ms, output ready);
endinterface

interface mkt_out_if;
	logic        valid;
	logic        ready;
	logic [6:0]  current_note;
	logic [6:0]  current_velocity;
	logic [15:0] intensity;
	logic [10:0] tempo_tenths;
	logic [15:0] beat_total;
	logic        switch_due;

	modport source (output valid, output current_note, output current_velocity,
		output intensity, output tempo_tenths, output beat_total,
		output switch_due, input ready);
	modport sink   (input valid, input current_note, input current_velocity,
		input intensity, input tempo_tenths, input beat_total,
		input switch_due, output ready);
endinterface

@@ sv/mkt_div.sv @@
// Shared restoring divider of the tempo tracker, one quotient bit a cycle.
// Depends on mkt_pkg. The quotient must fit in DIV_Q_W bits.
module mkt_div import mkt_pkg::*; #(
	parameter int W = 37
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [W-1:0]        num,
	input  logic [W-1:0]        den,
	output div_stat_t           stat,
	output logic [DIV_Q_W-1:0]  quo,
	output logic [W-1:0]        rem
);

	localparam int SH_W  = W + DIV_Q_W - 1;
	localparam int CNT_W = $clog2(DIV_Q_W + 1);

	logic [W-1:0]       rem_q;
	logic [SH_W-1:0]    dsh_q;
	logic [DIV_Q_W-1:0] quo_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               done_q;
	logic               ge;

	assign ge = {{(DIV_Q_W-1){1'b0}}, rem_q} >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(DIV_Q_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// The divisor starts shifted to the top quotient bit and walks down.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= {den, {(DIV_Q_W-1){1'b0}}};
		end else if (cnt_q != '0) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q[W-1:0];
			end
			quo_q <= {quo_q[DIV_Q_W-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;
	assign quo       = quo_q;
	assign rem       = rem_q;

endmodule

@@ sv/midi_kick_tempo_tracker_unit.sv @@
// From acceptance to result valid: a non-kick beat goes straight to posting its result; a
// kick first takes the bar-group modulo and, once enough intervals are held, the window sum
// and the range check, then for an in-range mean the tempo quotient, and then posts. One
// shared divider serves both the bar-group modulo and the tempo quotient.
// One beat at a time; the next can be accepted as soon as the result is valid.
// Reset is asynchronous: tempo 120.0 BPM, 8 bars, counters and notes zero.
module midi_kick_tempo_tracker_unit import mkt_pkg::*; #(
	parameter int WINDOW_DEPTH  = DEF_WINDOW_DEPTH,
	parameter int MIN_INTERVALS = DEF_MIN_INTERVALS
) (
	input  logic         clk,
	input  logic         arst_n,
	mkt_cfg_if.sink      cfg,
	mkt_in_if.sink       midi,
	mkt_out_if.source    result
);

	localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
	localparam int HEAD_W = $clog2(WINDOW_DEPTH);
	localparam int SUM_W  = 32 + FILL_W;
	localparam int DIV_W  = SUM_W + 1;

	// v * 65535 / 127 rounded: 65535 = 516 * 127 + 3, so the remainder term
	// (3v + 63) / 127 only steps at v = 22, 64 and 106.
	function automatic logic [15:0] note_intensity(input logic [6:0] v);
		logic [15:0] base;
		base = ({9'd0, v} << 9) + ({9'd0, v} << 2);
		return base + 16'(v >= 7'd22) + 16'(v >= 7'd64) + 16'(v >= 7'd106);
	endfunction

	mkt_state_t state_q, state_d;

	logic [6:0]  bars_q;
	logic [31:0] last_kick_q;
	logic        have_last_q;
	logic [FILL_W-1:0] fill_q;
	logic [HEAD_W-1:0] head_q;
	logic [10:0] tempo_q;
	logic [15:0] beat_q;
	logic [6:0]  note_q;
	logic [6:0]  vel_q;
	logic [15:0] int_q;
	logic        sw_q;
	logic        tempo_go_q;

	logic [31:0] window [WINDOW_DEPTH];
	logic [31:0] rd_q;
	logic [FILL_W-1:0] idx_q;
	logic        pipe_q;
	logic [SUM_W-1:0] acc_q;

	logic        res_valid_q;
	logic [6:0]  res_note_q;
	logic [6:0]  res_vel_q;
	logic [15:0] res_int_q;
	logic [10:0] res_tempo_q;
	logic [15:0] res_beat_q;
	logic        res_sw_q;

	logic        accept;
	logic        note_on;
	logic        is_kick;
	logic        is_release;
	logic        win_we;
	logic        sum_done;
	logic        in_range;
	logic        load_res;
	logic        div_start;
	logic [15:0] beat_next;
	logic [FILL_W-1:0] fill_next;
	logic [6:0]  bars_eff;
	logic [8:0]  group;
	logic [31:0] rel_prod;
	logic [31:0] rel_round;
	logic [FILL_W+6:0]  lo_b;
	logic [FILL_W+10:0] hi_b;
	logic [DIV_W-1:0]   tnum;
	logic [DIV_W-1:0]   div_num;
	logic [DIV_W-1:0]   div_den;
	div_stat_t          div_stat;
	logic [DIV_Q_W-1:0] div_quo;
	logic [DIV_W-1:0]   div_rem;

	assign accept     = midi.valid && midi.ready;
	assign note_on    = (midi.note_status == STATUS_NOTE_ON) && (midi.note_velocity != '0);
	assign is_kick    = note_on && (midi.note_pitch == KICK_PITCH_A ||
		midi.note_pitch == KICK_PITCH_B);
	assign is_release = !note_on && (midi.note_status == STATUS_NOTE_ON ||
		midi.note_status == STATUS_NOTE_OFF) && (midi.note_pitch == note_q);
	assign win_we     = accept && is_kick && have_last_q;

	assign beat_next = beat_q + 16'd1;
	assign fill_next = (fill_q == FILL_W'(WINDOW_DEPTH)) ? fill_q : fill_q + 1'b1;
	assign bars_eff  = (bars_q == '0) ? 7'd1 : bars_q;
	assign group     = {bars_eff, 2'b00};

	assign rel_prod  = {16'd0, int_q} * {16'd0, RELEASE_Q16};
	assign rel_round = rel_prod + 32'd32768;

	// Mean strictly between the bounds, tested on the sum against n times each.
	assign lo_b     = (FILL_W+7)'(fill_q) * (FILL_W+7)'(MEAN_LOW_MS);
	assign hi_b     = (FILL_W+11)'(fill_q) * (FILL_W+11)'(MEAN_HIGH_MS);
	assign in_range = (acc_q > SUM_W'(lo_b)) && (acc_q < SUM_W'(hi_b));
	assign tnum     = DIV_W'(fill_q) * DIV_W'(TEMPO_NUM2) + DIV_W'(acc_q);

	assign sum_done = (idx_q == fill_q) && !pipe_q;
	assign load_res = (state_q == ST_FINISH) && (!res_valid_q || result.ready);

	// The divider serves the bar-group modulo on acceptance and the tempo later.
	always_comb begin
		if (state_q == ST_IDLE) begin
			div_num = DIV_W'(beat_next);
			div_den = DIV_W'(group);
		end else begin
			div_num = tnum;
			div_den = {acc_q, 1'b0};
		end
	end

	mkt_div #(.W(DIV_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.stat   (div_stat),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (midi.valid) begin
					state_d = is_kick ? ST_MDIV : ST_FINISH;
				end
			end
			ST_MDIV: begin
				if (div_stat.done) begin
					state_d = tempo_go_q ? ST_SUM : ST_FINISH;
				end
			end
			ST_SUM: begin
				if (sum_done) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK:  state_d = in_range ? ST_TDIV : ST_FINISH;
			ST_TDIV: begin
				if (div_stat.done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (load_res) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		midi.ready = 1'b0;
		div_start  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				midi.ready = 1'b1;
				div_start  = midi.valid && is_kick;
			end
			ST_CHECK:  div_start = in_range;
			default: begin
				midi.ready = 1'b0;
				div_start  = 1'b0;
			end
		endcase
	end

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bars_q      <= BARS_RESET;
			last_kick_q <= '0;
			have_last_q <= 1'b0;
			fill_q      <= '0;
			head_q      <= '0;
			tempo_q     <= TEMPO_RESET;
			beat_q      <= '0;
			note_q      <= '0;
			vel_q       <= '0;
			int_q       <= '0;
			sw_q        <= 1'b0;
			tempo_go_q  <= 1'b0;
			idx_q       <= '0;
			pipe_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				bars_q <= cfg.data;
			end
			if (accept) begin
				sw_q       <= 1'b0;
				tempo_go_q <= 1'b0;
				if (note_on) begin
					note_q <= midi.note_pitch;
					vel_q  <= midi.note_velocity;
					int_q  <= note_intensity(midi.note_velocity);
				end else if (is_release) begin
					vel_q <= '0;
					int_q <= rel_round[31:16];
				end
				if (is_kick) begin
					last_kick_q <= midi.time_ms;
					have_last_q <= 1'b1;
					beat_q      <= beat_next;
					if (have_last_q) begin
						fill_q     <= fill_next;
						head_q     <= (head_q == HEAD_W'(WINDOW_DEPTH - 1)) ? '0 : head_q + 1'b1;
						tempo_go_q <= int'(fill_next) >= MIN_INTERVALS;
					end
				end
			end
			if (state_q == ST_MDIV && div_stat.done) begin
				sw_q   <= (beat_q != '0) && (div_rem == '0);
				idx_q  <= '0;
				pipe_q <= 1'b0;
			end
			// Read data is registered in rd_q, so the accumulate runs behind the read address.
			if (state_q == ST_SUM) begin
				pipe_q <= (idx_q != fill_q);
				if (idx_q != fill_q) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (state_q == ST_TDIV && div_stat.done) begin
				if (div_quo < DIV_Q_W'(TEMPO_MIN)) begin
					tempo_q <= TEMPO_MIN;
				end else if (div_quo > DIV_Q_W'(TEMPO_MAX)) begin
					tempo_q <= TEMPO_MAX;
				end else begin
					tempo_q <= div_quo[10:0];
				end
			end
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (win_we) begin
			window[head_q] <= midi.time_ms - last_kick_q;
		end
		rd_q <= window[idx_q[HEAD_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MDIV) begin
			acc_q <= '0;
		end else if (state_q == ST_SUM && pipe_q) begin
			acc_q <= acc_q + SUM_W'(rd_q);
		end
		if (load_res) begin
			res_note_q  <= note_q;
			res_vel_q   <= vel_q;
			res_int_q   <= int_q;
			res_tempo_q <= tempo_q;
			res_beat_q  <= beat_q;
			res_sw_q    <= sw_q;
		end
	end

	assign result.valid            = res_valid_q;
	assign result.current_note     = res_note_q;
	assign result.current_velocity = res_vel_q;
	assign result.intensity        = res_int_q;
	assign result.tempo_tenths     = res_tempo_q;
	assign result.beat_total       = res_beat_q;
	assign result.switch_due       = res_sw_q;

	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(fill_q) <= WINDOW_DEPTH)
		else $error("interval fill beyond window depth");

	a_tempo_range: assert property (@(posedge clk) disable iff (!arst_n)
		tempo_q >= TEMPO_MIN && tempo_q <= TEMPO_MAX)
		else $error("tempo outside clamp range");

	a_switch_beat: assert property (@(posedge clk) disable iff (!arst_n)
		load_res && sw_q |-> beat_q != '0)
		else $error("switch flag raised at beat count zero");

endmodule
